@@ rtl/core/rbc_pkg.sv @@
// ----------------------------------------------------------------------------
// rbc_pkg: region boundary classifier package
// Shared widths, register indexes and types of the classifier.
// ----------------------------------------------------------------------------
package rbc_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int X_W        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int Y_W        = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  localparam int CHAN_W     = 8;
  localparam int COLOR_W    = 24;
  localparam int DIM_W      = 11;
  localparam int COORD_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int NUM_SLOTS  = 3;

  localparam logic [DIM_W-1:0] DIM_RST = DIM_W'(1024);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REGION_COLOR  = 3'd0,
    REG_IMAGE_WIDTH   = 3'd1,
    REG_IMAGE_HEIGHT  = 3'd2,
    REG_OFFSET_X      = 3'd3,
    REG_OFFSET_Y      = 3'd4,
    REG_EMIT_INTERIOR = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               bnd;
  } rbc_slot_t;

endpackage

@@ rtl/core/rbc_if.sv @@
// ----------------------------------------------------------------------------
// rbc_if: classifier stream interfaces
// Pixel input channel and result output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rbc_pixel_if;
  logic                       valid;
  logic                       ready;
  logic [rbc_pkg::CHAN_W-1:0] pixel_blue;
  logic [rbc_pkg::CHAN_W-1:0] pixel_green;
  logic [rbc_pkg::CHAN_W-1:0] pixel_red;

  modport source (output valid, pixel_blue, pixel_green, pixel_red, input ready);
  modport sink   (input valid, pixel_blue, pixel_green, pixel_red, output ready);
endinterface

interface rbc_result_if;
  logic                        valid;
  logic                        ready;
  logic [rbc_pkg::COORD_W-1:0] out_x;
  logic [rbc_pkg::COORD_W-1:0] out_y;
  logic                        out_border;
  logic                        last_of_run;

  modport source (output valid, out_x, out_y, out_border, last_of_run, input ready);
  modport sink   (input valid, out_x, out_y, out_border, last_of_run, output ready);
endinterface

@@ rtl/core/region_boundary_classifier_top.sv @@
// ----------------------------------------------------------------------------
// region_boundary_classifier_top: 3x3 region boundary classifier
// Classifies raster-order RGB pixels against a region color and reports
// boundary (and optionally interior) region pixels with offset coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   in_pix  : one RGB pixel per transaction, row-major raster order.
//   out_res : result transactions (x, y, out_border, last_of_run); one
//             pixel causes zero to three results, last_of_run marks the
//             final one of that pixel.
//   cfg_*   : register writes, only while no transaction is in flight.
//             Writing image_width or image_height restarts the frame.
// Path: an accepted pixel is held in the stage 1 register, then in the
//   stage 2 result slots, from which its first result shows.
// Throughput: one pixel per cycle while each pixel yields at most one
//   result and the receiver takes every result; a pixel with two or three
//   results holds input while the single result port drains the slots.
// Line buffers: one 2-bit-wide memory of MAX_WIDTH entries, one read and one
//   write per cycle, filled by rows 0 and 1 of each frame before use.
// Reset: pipeline empties, registers take reset values; the line buffer
//   holds no valid contents until written. A stalled receiver holds the
//   result slots, then the input register, then in_pix.ready drops.
// ----------------------------------------------------------------------------
module region_boundary_classifier_top (
  input  logic                           clk,
  input  logic                           rst_n,
  rbc_pixel_if.sink                      in_pix,
  rbc_result_if.source                   out_res,
  input  logic                           cfg_we,
  input  logic [rbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rbc_pkg::CFG_DATA_W-1:0] cfg_data
);

  // configuration
  logic [rbc_pkg::COLOR_W-1:0] color_r;
  logic [rbc_pkg::DIM_W-1:0]   width_r;
  logic [rbc_pkg::DIM_W-1:0]   height_r;
  logic [rbc_pkg::COORD_W-1:0] offset_x_r;
  logic [rbc_pkg::COORD_W-1:0] offset_y_r;
  logic                        emit_int_r;
  logic                        restart;

  logic [rbc_pkg::X_W-1:0] wm1;
  logic [rbc_pkg::Y_W-1:0] hm1;

  // counters and window
  logic [rbc_pkg::X_W-1:0] col_r;
  logic [rbc_pkg::Y_W-1:0] row_r;
  logic [8:0]              window_r;

  // stage 1
  logic                    s1_valid_r;
  logic                    s1_cur_r;
  logic [rbc_pkg::X_W-1:0] s1_x_r;
  logic [rbc_pkg::Y_W-1:0] s1_y_r;

  // line buffer: bit 0 older row, bit 1 prior row
  logic [1:0]              line_mem [rbc_pkg::MAX_WIDTH];
  logic [1:0]              rd_r;
  logic [1:0]              wr_data;

  // stage 2
  rbc_pkg::rbc_slot_t              s2_slot_r [rbc_pkg::NUM_SLOTS];
  logic [rbc_pkg::NUM_SLOTS-1:0]   s2_mask_r;
  rbc_pkg::rbc_slot_t              slot_nxt [rbc_pkg::NUM_SLOTS];
  logic [rbc_pkg::NUM_SLOTS-1:0]   mask_nxt;
  logic [rbc_pkg::NUM_SLOTS-1:0]   sel;
  rbc_pkg::rbc_slot_t              out_slot;

  logic in_fire, out_fire, s2_free, s1_commit;
  logic cur_match;
  logic old_bit, pri_bit;
  logic [8:0] win_nxt;
  logic a_bnd;
  logic [rbc_pkg::COORD_W-1:0] base_x, base_y;

  // clamped dimensions minus one
  always_comb begin
    if (width_r == '0) begin
      wm1 = '0;
    end else if (int'(width_r) > rbc_pkg::MAX_WIDTH) begin
      wm1 = rbc_pkg::X_W'(rbc_pkg::MAX_WIDTH - 1);
    end else begin
      wm1 = rbc_pkg::X_W'(width_r - 1'b1);
    end
    if (height_r == '0) begin
      hm1 = '0;
    end else if (int'(height_r) > rbc_pkg::MAX_HEIGHT) begin
      hm1 = rbc_pkg::Y_W'(rbc_pkg::MAX_HEIGHT - 1);
    end else begin
      hm1 = rbc_pkg::Y_W'(height_r - 1'b1);
    end
  end

  assign restart = cfg_we && (cfg_index == rbc_pkg::REG_IMAGE_WIDTH ||
                              cfg_index == rbc_pkg::REG_IMAGE_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r    <= '0;
      width_r    <= rbc_pkg::DIM_RST;
      height_r   <= rbc_pkg::DIM_RST;
      offset_x_r <= '0;
      offset_y_r <= '0;
      emit_int_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        rbc_pkg::REG_REGION_COLOR:  color_r    <= cfg_data[rbc_pkg::COLOR_W-1:0];
        rbc_pkg::REG_IMAGE_WIDTH:   width_r    <= cfg_data[rbc_pkg::DIM_W-1:0];
        rbc_pkg::REG_IMAGE_HEIGHT:  height_r   <= cfg_data[rbc_pkg::DIM_W-1:0];
        rbc_pkg::REG_OFFSET_X:      offset_x_r <= cfg_data[rbc_pkg::COORD_W-1:0];
        rbc_pkg::REG_OFFSET_Y:      offset_y_r <= cfg_data[rbc_pkg::COORD_W-1:0];
        rbc_pkg::REG_EMIT_INTERIOR: emit_int_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // handshakes
  assign out_fire  = out_res.valid && out_res.ready;
  assign s2_free   = (s2_mask_r == '0) || (out_fire && $onehot(s2_mask_r));
  assign s1_commit = s1_valid_r && s2_free;
  assign in_pix.ready = !s1_valid_r || s1_commit;
  assign in_fire   = in_pix.valid && in_pix.ready;

  assign cur_match = ({in_pix.pixel_red, in_pix.pixel_green, in_pix.pixel_blue} == color_r);

  // counters, stage 1 register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
        if (col_r == wm1) begin
          col_r <= '0;
          row_r <= (row_r == hm1) ? '0 : row_r + 1'b1;
        end else begin
          col_r <= col_r + 1'b1;
        end
      end else if (s1_commit) begin
        s1_valid_r <= 1'b0;
      end
      if (restart) begin
        col_r <= '0;
        row_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cur_r <= cur_match;
      s1_x_r   <= col_r;
      s1_y_r   <= row_r;
    end
  end

  // line buffer, read at accept, written at commit, write forwarded
  assign wr_data = {s1_cur_r, pri_bit};

  always_ff @(posedge clk) begin
    if (s1_commit) begin
      line_mem[s1_x_r] <= wr_data;
    end
    if (in_fire) begin
      rd_r <= (s1_commit && s1_x_r == col_r) ? wr_data : line_mem[col_r];
    end
  end

  assign old_bit = rd_r[0];
  assign pri_bit = rd_r[1];
  assign win_nxt = {window_r[5:0], s1_cur_r, pri_bit, old_bit};
  assign a_bnd   = (s1_x_r == rbc_pkg::X_W'(1)) || (win_nxt != 9'h1FF);
  assign base_x  = rbc_pkg::COORD_W'(s1_x_r) + offset_x_r;
  assign base_y  = rbc_pkg::COORD_W'(s1_y_r) + offset_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
    end else if (restart) begin
      window_r <= '0;
    end else if (s1_commit) begin
      window_r <= win_nxt;
    end
  end

  // stage 1 classification into result slots
  always_comb begin
    slot_nxt[0].x   = base_x - 1'b1;
    slot_nxt[0].y   = base_y - 1'b1;
    slot_nxt[0].bnd = a_bnd;
    slot_nxt[1].x   = base_x;
    slot_nxt[1].y   = base_y - 1'b1;
    slot_nxt[1].bnd = 1'b1;
    slot_nxt[2].x   = base_x;
    slot_nxt[2].y   = base_y;
    slot_nxt[2].bnd = 1'b1;
    mask_nxt[0] = (s1_y_r >= rbc_pkg::Y_W'(2)) && (s1_x_r != '0) && win_nxt[4] &&
                  (a_bnd || emit_int_r);
    mask_nxt[1] = (s1_y_r >= rbc_pkg::Y_W'(2)) && (s1_x_r == wm1) && pri_bit;
    mask_nxt[2] = ((s1_y_r == '0) || (s1_y_r == hm1)) && s1_cur_r;
  end

  // stage 2 result slots
  assign sel = s2_mask_r & (~s2_mask_r + 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_mask_r <= '0;
    end else if (s1_commit) begin
      s2_mask_r <= mask_nxt;
    end else if (out_fire) begin
      s2_mask_r <= s2_mask_r & ~sel;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_commit) begin
      s2_slot_r <= slot_nxt;
    end
  end

  always_comb begin
    out_slot = s2_slot_r[rbc_pkg::NUM_SLOTS-1];
    for (int i = rbc_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
      if (s2_mask_r[i]) begin
        out_slot = s2_slot_r[i];
      end
    end
  end

  assign out_res.valid       = (s2_mask_r != '0);
  assign out_res.out_x       = out_slot.x;
  assign out_res.out_y       = out_slot.y;
  assign out_res.out_border  = out_slot.bnd;
  assign out_res.last_of_run = ((s2_mask_r & ~sel) == '0);

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_res.valid && !s1_valid_r)
    else $error("pipeline not empty after reset");

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= wm1)
    else $error("column counter beyond frame width");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_commit && !restart |=> s1_valid_r && $stable(s1_x_r) &&
                                             $stable(s1_y_r) && $stable(s1_cur_r))
    else $error("stage 1 item lost while result slots busy");
`endif

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb: region boundary classifier testbench
// Streams RGB frames through the classifier and predicts every boundary and
// interior result from a shadow copy of the line buffers, the 3x3 window and
// the registers. Directed frames hit the register extremes, clamping,
// coordinate wrap and mid-frame color changes. Random frames follow, with
// bursts of source gaps and sink stalls. A tall one-column frame and a
// clamped wide frame run last with no idling.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam logic [rbc_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [rbc_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [rbc_pkg::COORD_W-1:0] x;
    logic [rbc_pkg::COORD_W-1:0] y;
    logic                        bnd;
    logic                        last;
  } boundary_hit_t;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [rbc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [rbc_pkg::CFG_DATA_W-1:0] cfg_data;

  rbc_pixel_if  pix_if ();
  rbc_result_if res_if ();

  region_boundary_classifier_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pix    (pix_if),
    .out_res   (res_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // shadow registers
  logic [rbc_pkg::COLOR_W-1:0] sh_color;
  logic [rbc_pkg::DIM_W-1:0]   sh_width;
  logic [rbc_pkg::DIM_W-1:0]   sh_height;
  logic [rbc_pkg::COORD_W-1:0] sh_off_x;
  logic [rbc_pkg::COORD_W-1:0] sh_off_y;
  logic                        sh_emit;

  // shadow frame state
  bit                 two_rows_up [rbc_pkg::MAX_WIDTH];
  bit                 one_row_up  [rbc_pkg::MAX_WIDTH];
  logic [8:0]         win_bits;
  int unsigned        cur_col;
  int unsigned        cur_row;

  boundary_hit_t      expected_hits [$];
  boundary_hit_t      got_hit;

  bit                 src_idle_en;
  bit                 sink_stall_en;
  int unsigned        stall_left = 0;
  int unsigned        cycle_count = 0;
  int unsigned        fail_count = 0;
  int unsigned        pixels_sent;
  int unsigned        results_checked = 0;
  int unsigned        interior_seen = 0;

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // sink back-pressure bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      res_if.ready <= (stall_left == 1);
    end else if (sink_stall_en && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 16);
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready) begin
      results_checked <= results_checked + 1;
      if (expected_hits.size() == 0) begin
        $error("unexpected result transaction: x %0d y %0d bnd %0d",
               res_if.out_x, res_if.out_y, res_if.out_border);
        fail_count <= fail_count + 1;
      end else begin
        got_hit = expected_hits.pop_front();
        if (!res_if.out_border) interior_seen <= interior_seen + 1;
        if (res_if.out_x !== got_hit.x) begin
          $error("out_x mismatch: expected %0d, actual %0d", got_hit.x, res_if.out_x);
          fail_count <= fail_count + 1;
        end
        if (res_if.out_y !== got_hit.y) begin
          $error("out_y mismatch: expected %0d, actual %0d", got_hit.y, res_if.out_y);
          fail_count <= fail_count + 1;
        end
        if (res_if.out_border !== got_hit.bnd) begin
          $error("out_border mismatch: expected %0d, actual %0d",
                 got_hit.bnd, res_if.out_border);
          fail_count <= fail_count + 1;
        end
        if (res_if.last_of_run !== got_hit.last) begin
          $error("last_of_run mismatch: expected %0d, actual %0d",
                 got_hit.last, res_if.last_of_run);
          fail_count <= fail_count + 1;
        end
      end
    end
  end

  function automatic int unsigned clamp_dim(input logic [rbc_pkg::DIM_W-1:0] v,
                                            input int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  function automatic boundary_hit_t make_hit(input int unsigned x, input int unsigned y,
                                             input logic bnd);
    boundary_hit_t h;
    h.x    = rbc_pkg::COORD_W'(x + sh_off_x);
    h.y    = rbc_pkg::COORD_W'(y + sh_off_y);
    h.bnd  = bnd;
    h.last = 1'b0;
    return h;
  endfunction

  task automatic restart_frame();
    win_bits = '0;
    cur_col  = 0;
    cur_row  = 0;
  endtask

  task automatic classify_pixel(input logic [rbc_pkg::COLOR_W-1:0] px);
    int unsigned w, h, x, y;
    logic [rbc_pkg::X_W-1:0] xi;
    logic cur, old_b, pri_b, bnd;
    boundary_hit_t hits [$];
    boundary_hit_t hit;
    w = clamp_dim(sh_width, rbc_pkg::MAX_WIDTH);
    h = clamp_dim(sh_height, rbc_pkg::MAX_HEIGHT);
    x = (cur_col >= w) ? w - 1 : cur_col;
    y = (cur_row >= h) ? h - 1 : cur_row;
    xi = rbc_pkg::X_W'(x);
    cur   = (px == sh_color);
    old_b = two_rows_up[xi];
    pri_b = one_row_up[xi];
    win_bits = {win_bits[5:0], cur, pri_b, old_b};
    if (y >= 2) begin
      if (x >= 1 && win_bits[4]) begin
        bnd = (x == 1) || (win_bits != 9'h1FF);
        if (bnd || sh_emit) hits = {hits, make_hit(x - 1, y - 1, bnd)};
      end
      if (x == w - 1 && pri_b) hits = {hits, make_hit(x, y - 1, 1'b1)};
    end
    if ((y == 0 || y == h - 1) && cur) hits = {hits, make_hit(x, y, 1'b1)};
    two_rows_up[xi] = pri_b;
    one_row_up[xi]  = cur;
    if (x >= w - 1) begin
      cur_col = 0;
      cur_row = (y >= h - 1) ? 0 : y + 1;
    end else begin
      cur_col = x + 1;
      cur_row = y;
    end
    for (int i = 0; i < hits.size(); i++) begin
      hit = hits[i];
      hit.last = (i == hits.size() - 1);
      expected_hits = {expected_hits, hit};
    end
  endtask

  task automatic send_pixel(input logic [rbc_pkg::COLOR_W-1:0] px);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      pix_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    pix_if.valid       <= 1'b1;
    pix_if.pixel_blue  <= px[7:0];
    pix_if.pixel_green <= px[15:8];
    pix_if.pixel_red   <= px[23:16];
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
    classify_pixel(px);
    pixels_sent++;
  endtask

  // wait for every predicted result, then let the pipeline empty
  task automatic drain_results();
    pix_if.valid <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rbc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rbc_pkg::CFG_DATA_W-1:0] data);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      rbc_pkg::REG_REGION_COLOR:  sh_color = data[rbc_pkg::COLOR_W-1:0];
      rbc_pkg::REG_IMAGE_WIDTH: begin
        sh_width = data[rbc_pkg::DIM_W-1:0];
        restart_frame();
      end
      rbc_pkg::REG_IMAGE_HEIGHT: begin
        sh_height = data[rbc_pkg::DIM_W-1:0];
        restart_frame();
      end
      rbc_pkg::REG_OFFSET_X:      sh_off_x = data[rbc_pkg::COORD_W-1:0];
      rbc_pkg::REG_OFFSET_Y:      sh_off_y = data[rbc_pkg::COORD_W-1:0];
      rbc_pkg::REG_EMIT_INTERIOR: sh_emit = data[0];
      default: ;
    endcase
  endtask

  function automatic logic [rbc_pkg::COLOR_W-1:0] pick_pixel();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return sh_color;
    if (sel < 8) return sh_color ^ (24'h1 << $urandom_range(0, 23));
    return rbc_pkg::COLOR_W'($urandom);
  endfunction

  function automatic logic [rbc_pkg::CFG_DATA_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0:       return 24'd0;
      1:       return rbc_pkg::CFG_DATA_W'($urandom_range(1025, 2047));
      2:       return 24'd1024;
      default: return rbc_pkg::CFG_DATA_W'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic logic [rbc_pkg::CFG_DATA_W-1:0] pick_offset();
    case ($urandom_range(0, 7))
      0:       return 24'd0;
      1:       return 24'd64512;
      2:       return 24'hFFFFFF;
      default: return rbc_pkg::CFG_DATA_W'($urandom_range(0, 300));
    endcase
  endfunction

  task automatic test_reset_defaults();
    // 1024x1024 frame, color 0, only row 0 reported
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h000000);
    send_pixel(24'h000000);
  endtask

  task automatic test_tiny_frames();
    write_reg(rbc_pkg::REG_IMAGE_WIDTH, 24'd0);
    write_reg(rbc_pkg::REG_IMAGE_HEIGHT, 24'd0);
    send_pixel(24'h000000);
    send_pixel(24'h000100);
    write_reg(rbc_pkg::REG_REGION_COLOR, 24'hFFFFFF);
    write_reg(rbc_pkg::REG_EMIT_INTERIOR, 24'd1);
    write_reg(rbc_pkg::REG_IMAGE_WIDTH, 24'd3);
    write_reg(rbc_pkg::REG_IMAGE_HEIGHT, 24'd3);
    repeat (9) send_pixel(24'hFFFFFF);
  endtask

  task automatic test_offsets_wrap();
    write_reg(rbc_pkg::REG_OFFSET_X, 24'hFFFFFF);
    write_reg(rbc_pkg::REG_OFFSET_Y, 24'd64512);
    write_reg(rbc_pkg::REG_IMAGE_WIDTH, 24'd2);
    write_reg(rbc_pkg::REG_IMAGE_HEIGHT, 24'd1);
    send_pixel(24'hFFFFFF);
    send_pixel(24'hFFFFFF);
  endtask

  task automatic test_spare_index();
    write_reg(REG_SPARE_6, 24'hFFFFFF);
    write_reg(REG_SPARE_7, 24'h000000);
    send_pixel(24'hFFFFFF);
    send_pixel(24'hFFFFFE);
  endtask

  task automatic test_color_midframe();
    write_reg(rbc_pkg::REG_OFFSET_X, 24'd0);
    write_reg(rbc_pkg::REG_OFFSET_Y, 24'd0);
    write_reg(rbc_pkg::REG_REGION_COLOR, 24'h123456);
    write_reg(rbc_pkg::REG_IMAGE_WIDTH, 24'd3);
    write_reg(rbc_pkg::REG_IMAGE_HEIGHT, 24'd3);
    repeat (4) send_pixel(24'h123456);
    write_reg(rbc_pkg::REG_REGION_COLOR, 24'h654321);
    send_pixel(24'h123456);
    repeat (4) send_pixel(24'h654321);
  endtask

  task automatic test_random_frames();
    int unsigned w, h, n, sent;
    sent = 0;
    while (sent < 70) begin
      src_idle_en   = ($urandom_range(0, 3) != 0);
      sink_stall_en = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 5))
          0:       write_reg(rbc_pkg::REG_REGION_COLOR, 24'h000000);
          1:       write_reg(rbc_pkg::REG_REGION_COLOR, 24'hFFFFFF);
          default: write_reg(rbc_pkg::REG_REGION_COLOR, rbc_pkg::CFG_DATA_W'($urandom));
        endcase
      end
      if ($urandom_range(0, 3) != 0) begin
        write_reg(rbc_pkg::REG_IMAGE_WIDTH, pick_dim());
        write_reg(rbc_pkg::REG_IMAGE_HEIGHT, pick_dim());
      end
      write_reg(rbc_pkg::REG_OFFSET_X, pick_offset());
      write_reg(rbc_pkg::REG_OFFSET_Y, pick_offset());
      write_reg(rbc_pkg::REG_EMIT_INTERIOR, rbc_pkg::CFG_DATA_W'($urandom_range(0, 1)));
      w = clamp_dim(sh_width, rbc_pkg::MAX_WIDTH);
      h = clamp_dim(sh_height, rbc_pkg::MAX_HEIGHT);
      if (w * h <= 24) n = w * h * $urandom_range(1, 2);
      else n = $urandom_range(4, 24);
      repeat (n) send_pixel(pick_pixel());
      sent += n;
    end
  endtask

  task automatic test_max_height();
    write_reg(rbc_pkg::REG_OFFSET_X, 24'd0);
    write_reg(rbc_pkg::REG_OFFSET_Y, 24'd0);
    write_reg(rbc_pkg::REG_EMIT_INTERIOR, 24'd1);
    write_reg(rbc_pkg::REG_IMAGE_WIDTH, 24'd1);
    write_reg(rbc_pkg::REG_IMAGE_HEIGHT, 24'hFFFFFF);
    repeat (20) send_pixel(pick_pixel());
  endtask

  task automatic test_max_width();
    write_reg(rbc_pkg::REG_IMAGE_WIDTH, 24'h0007FF);
    write_reg(rbc_pkg::REG_IMAGE_HEIGHT, 24'd3);
    repeat (20) send_pixel(pick_pixel());
  endtask

  initial begin
    clk                = 1'b0;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    pix_if.valid       = 1'b0;
    pix_if.pixel_blue  = '0;
    pix_if.pixel_green = '0;
    pix_if.pixel_red   = '0;
    src_idle_en        = 1'b1;
    sink_stall_en      = 1'b1;
    pixels_sent        = 0;
    sh_color           = '0;
    sh_width           = rbc_pkg::DIM_RST;
    sh_height          = rbc_pkg::DIM_RST;
    sh_off_x           = '0;
    sh_off_y           = '0;
    sh_emit            = 1'b0;
    restart_frame();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_tiny_frames();
    test_offsets_wrap();
    test_spare_index();
    test_color_midframe();
    test_random_frames();
    src_idle_en   = 1'b0;
    sink_stall_en = 1'b0;
    test_max_height();
    test_max_width();
    drain_results();

    $display("summary: %0d pixels, %0d results checked, %0d of them interior",
             pixels_sent, results_checked, interior_seen);
    $display("summary: clamped and tiny frames, offset wrap, mid-frame color change");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
